### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh - assertion helpers
// Clocked assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

### rtl/sdel_pkg.sv
// ---------------------------------------------------------------------------
// sdel_pkg - shared types for the sorted double-ended list
// Transaction payloads, mode and status codes, cell control structs.
// ---------------------------------------------------------------------------
package sdel_pkg;

	localparam int SDEL_CAPACITY = 16;
	localparam int KEY_W         = 32;
	localparam int TAG_W         = 32;
	localparam int OUT_COUNT_W   = 5;

	// operation modes
	localparam logic [2:0] MODE_PUSH_HEAD = 3'd0;
	localparam logic [2:0] MODE_PUSH_TAIL = 3'd1;
	localparam logic [2:0] MODE_SORTED    = 3'd2;
	localparam logic [2:0] MODE_POP_HEAD  = 3'd3;
	localparam logic [2:0] MODE_POP_TAIL  = 3'd4;
	localparam logic [2:0] MODE_REMOVE    = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [2:0]              mode;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        payload;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [KEY_W-1:0] out_key;
		logic [TAG_W-1:0]        out_payload;
		logic [OUT_COUNT_W-1:0]  out_count;
	} out_item_t;

	// what the row of cells does this cycle
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_INSERT,
		ACT_DELETE
	} act_t;

	// where the insert or delete starts
	typedef enum logic [1:0] {
		WH_HEAD,
		WH_TAIL,
		WH_FIRST
	} where_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

	// broadcast to every cell
	typedef struct packed {
		logic                    cmp_en;
		act_t                    act;
		where_t                  where;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} sdel_op_t;

	// compare results reported by each cell
	typedef struct packed {
		logic gt;
		logic eq;
		logic tail;
	} sdel_flag_t;

endpackage

### rtl/sdel_chan_if.sv
// ---------------------------------------------------------------------------
// sdel_chan_if - valid/ready channel
// Carries one payload per transaction between a source and a sink.
// ---------------------------------------------------------------------------
interface sdel_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/sdel_cell.sv
// ---------------------------------------------------------------------------
// sdel_cell - one entry of the list
// Holds a key and tag, compares against the request key and shifts
// toward either neighbor on insert or delete.
// ---------------------------------------------------------------------------
module sdel_cell #(
	parameter int CAPACITY = sdel_pkg::SDEL_CAPACITY,
	parameter int IDX      = 0,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sdel_pkg::sdel_op_t               op,
	input  logic [CW-1:0]                    count,
	input  logic signed [sdel_pkg::KEY_W-1:0] left_key,
	input  logic [sdel_pkg::TAG_W-1:0]       left_tag,
	input  logic signed [sdel_pkg::KEY_W-1:0] right_key,
	input  logic [sdel_pkg::TAG_W-1:0]       right_tag,
	input  logic                             ge_in,
	output logic                             ge_out,
	input  logic signed [sdel_pkg::KEY_W-1:0] rem_key_in,
	input  logic [sdel_pkg::TAG_W-1:0]       rem_tag_in,
	output logic signed [sdel_pkg::KEY_W-1:0] rem_key_out,
	output logic [sdel_pkg::TAG_W-1:0]       rem_tag_out,
	output logic signed [sdel_pkg::KEY_W-1:0] key,
	output logic [sdel_pkg::TAG_W-1:0]       tag,
	output sdel_pkg::sdel_flag_t             flag
);
	import sdel_pkg::*;

	logic signed [KEY_W-1:0] key_q;
	logic [TAG_W-1:0]        tag_q;
	logic                    gt_q;
	logic                    eq_q;
	logic                    live;
	logic                    is_tail;
	logic                    start;
	logic                    first;

	assign live    = CW'(IDX) < count;
	assign is_tail = CW'(IDX + 1) == count;

	// pick where this cell starts the shift
	always_comb begin
		start = 1'b0;
		case (op.where)
			WH_HEAD:  start = (IDX == 0);
			WH_TAIL:  start = (op.act == ACT_INSERT) ? (CW'(IDX) == count) : is_tail;
			WH_FIRST: start = (op.act == ACT_INSERT) ? gt_q : eq_q;
			default:  start = 1'b0;
		endcase
		if (op.act == ACT_NONE)
			start = 1'b0;
	end

	assign ge_out = ge_in | start;
	assign first  = ge_out & ~ge_in;

	// pass the removed entry down the chain
	assign rem_key_out = rem_key_in | ((op.act == ACT_DELETE && first) ? key_q : '0);
	assign rem_tag_out = rem_tag_in | ((op.act == ACT_DELETE && first) ? tag_q : '0);

	// latch compare flags against the request key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (op.cmp_en) begin
			gt_q <= live && (key_q > op.key);
			eq_q <= live && (key_q == op.key);
		end
	end

	// shift right on insert, left on delete
	always_ff @(posedge clk) begin
		if (op.act == ACT_INSERT && ge_out) begin
			key_q <= ge_in ? left_key : op.key;
			tag_q <= ge_in ? left_tag : op.tag;
		end else if (op.act == ACT_DELETE && ge_out) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end
	end

	assign key       = key_q;
	assign tag       = tag_q;
	assign flag.gt   = gt_q;
	assign flag.eq   = eq_q;
	assign flag.tail = is_tail;

endmodule

### rtl/sorted_double_ended_list.sv
// ---------------------------------------------------------------------------
// sorted_double_ended_list - ordered double-ended store
// Row of CAPACITY cells with head/tail push, sorted insert, head/tail
// pop and remove by key.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                  | accept
//  in_ch   | in  | mode, key, payload                       | valid && ready
//  out_ch  | out | status, out_key, out_payload, out_count  | valid && ready
//
// Each operation passes through three steps: accept, a compare cycle in which every
// cell registers its key against the request key, and an apply cycle in
// which the row shifts and the result is loaded into the output register.
// The apply cycle waits while a previous result is still held at out_ch.
// A new transaction is taken as soon as the apply cycle is done.
// Reset clears the fill count and control; entry contents need no reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_double_ended_list #(
	parameter int CAPACITY = sdel_pkg::SDEL_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	sdel_chan_if.sink   in_ch,
	sdel_chan_if.source out_ch
);
	import sdel_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	state_t    state_q;
	state_t    state_d;
	in_item_t  req_q;
	logic [CW-1:0] count_q;
	out_item_t out_q;
	logic      out_valid_q;

	logic      in_ready;
	logic      cmp_en;
	logic      apply_en;
	logic      out_free;

	act_t      act;
	where_t    where;
	logic [1:0] status;
	sdel_op_t  op;

	logic      empty;
	logic      full;
	logic      gt_head;
	logic      eq_head;
	logic      tail_gt;
	logic      tail_eq;
	logic      any_eq;

	logic                    ge_w      [CAPACITY+1];
	logic signed [KEY_W-1:0] rem_key_w [CAPACITY+1];
	logic [TAG_W-1:0]        rem_tag_w [CAPACITY+1];
	logic signed [KEY_W-1:0] key_w     [CAPACITY];
	logic [TAG_W-1:0]        tag_w     [CAPACITY];
	sdel_flag_t              flag_w    [CAPACITY];
	logic [CAPACITY-1:0]     tail_gt_v;
	logic [CAPACITY-1:0]     tail_eq_v;
	logic [CAPACITY-1:0]     eq_v;

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_ch.valid) state_d = S_CMP;
			S_CMP:   state_d = S_APPLY;
			S_APPLY: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready = 1'b0;
		cmp_en   = 1'b0;
		apply_en = 1'b0;
		case (state_q)
			S_IDLE:  in_ready = 1'b1;
			S_CMP:   cmp_en   = 1'b1;
			S_APPLY: apply_en = out_free;
			default: in_ready = 1'b0;
		endcase
	end

	assign out_free    = !out_valid_q || out_ch.ready;
	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// hold the request
	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid)
			req_q <= in_ch.data;
	end

	// reduce cell flags
	assign empty   = count_q == '0;
	assign full    = count_q == CW'(CAPACITY);
	assign gt_head = flag_w[0].gt;
	assign eq_head = flag_w[0].eq;
	assign tail_gt = |tail_gt_v;
	assign tail_eq = |tail_eq_v;
	assign any_eq  = |eq_v;

	// decode the operation
	always_comb begin
		act    = ACT_NONE;
		where  = WH_HEAD;
		status = ST_OK;
		case (req_q.mode)
			MODE_PUSH_HEAD, MODE_PUSH_TAIL, MODE_SORTED: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					act = ACT_INSERT;
					if (req_q.mode == MODE_PUSH_TAIL)
						where = WH_TAIL;
					else if (req_q.mode == MODE_SORTED && !empty && !gt_head)
						where = tail_gt ? WH_FIRST : WH_TAIL;
				end
			end
			MODE_POP_HEAD, MODE_POP_TAIL, MODE_REMOVE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (req_q.mode == MODE_POP_HEAD) begin
					act = ACT_DELETE;
				end else if (req_q.mode == MODE_POP_TAIL) begin
					act   = ACT_DELETE;
					where = WH_TAIL;
				end else if (eq_head) begin
					act = ACT_DELETE;
				end else if (tail_eq) begin
					act   = ACT_DELETE;
					where = WH_TAIL;
				end else if (any_eq) begin
					act   = ACT_DELETE;
					where = WH_FIRST;
				end else begin
					status = ST_NOTFOUND;
				end
			end
			default: status = ST_OK;
		endcase
	end

	assign op.cmp_en = cmp_en;
	assign op.act    = apply_en ? act : ACT_NONE;
	assign op.where  = where;
	assign op.key    = req_q.key;
	assign op.tag    = req_q.payload;

	assign ge_w[0]      = 1'b0;
	assign rem_key_w[0] = '0;
	assign rem_tag_w[0] = '0;

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [KEY_W-1:0] lk;
		logic [TAG_W-1:0]        lt;
		logic signed [KEY_W-1:0] rk;
		logic [TAG_W-1:0]        rt;

		if (i == 0) begin : g_head
			assign lk = req_q.key;
			assign lt = req_q.payload;
		end else begin : g_mid
			assign lk = key_w[i-1];
			assign lt = tag_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rk = key_w[i];
			assign rt = tag_w[i];
		end else begin : g_body
			assign rk = key_w[i+1];
			assign rt = tag_w[i+1];
		end

		sdel_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i),
			.CW       (CW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.count       (count_q),
			.left_key    (lk),
			.left_tag    (lt),
			.right_key   (rk),
			.right_tag   (rt),
			.ge_in       (ge_w[i]),
			.ge_out      (ge_w[i+1]),
			.rem_key_in  (rem_key_w[i]),
			.rem_tag_in  (rem_tag_w[i]),
			.rem_key_out (rem_key_w[i+1]),
			.rem_tag_out (rem_tag_w[i+1]),
			.key         (key_w[i]),
			.tag         (tag_w[i]),
			.flag        (flag_w[i])
		);

		assign tail_gt_v[i] = flag_w[i].tail & flag_w[i].gt;
		assign tail_eq_v[i] = flag_w[i].tail & flag_w[i].eq;
		assign eq_v[i]      = flag_w[i].eq;
	end

	// advance the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.act == ACT_INSERT) begin
			count_q <= count_q + CW'(1);
		end else if (op.act == ACT_DELETE) begin
			count_q <= count_q - CW'(1);
		end
	end

	// output register: load on apply, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (apply_en)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (apply_en) begin
			out_q.status      <= status;
			out_q.out_key     <= rem_key_w[CAPACITY];
			out_q.out_payload <= rem_tag_w[CAPACITY];
			case (op.act)
				ACT_INSERT: out_q.out_count <= OUT_COUNT_W'(count_q + CW'(1));
				ACT_DELETE: out_q.out_count <= OUT_COUNT_W'(count_q - CW'(1));
				default:    out_q.out_count <= OUT_COUNT_W'(count_q);
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// checks
	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CW'(CAPACITY))
	`ASSERT_NEVER(a_del_empty, clk, arst_n, op.act == ACT_DELETE && empty)
	`ASSERT_CLK(a_ins_count, clk, arst_n,
		op.act == ACT_INSERT |=> count_q == $past(count_q) + CW'(1))
	`ASSERT_CLK(a_apply_loads, clk, arst_n, apply_en |=> out_valid_q)

endmodule

### verif/tb_sorted_double_ended_list.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sorted_double_ended_list - self-checking bench for the ordered store
// Drives push, sorted insert, pop and remove-by-key transactions through
// the input channel, keeps its own copy of the list to work out each reply,
// and checks every reply field by field under random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_sorted_double_ended_list;
	import sdel_pkg::*;

	// reserved mode encodings, expected to leave the list alone
	localparam logic [2:0] MODE_RSVD_6 = 3'd6;
	localparam logic [2:0] MODE_RSVD_7 = 3'd7;

	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	localparam int RANDOM_OPS = 550;

	// one queued operation, optionally held back until the list is quiet
	typedef struct {
		in_item_t item;
		bit       drain;
	} list_cmd_t;

	logic clk;
	logic arst_n;

	sdel_chan_if #(.payload_t(in_item_t))  in_ch ();
	sdel_chan_if #(.payload_t(out_item_t)) out_ch ();

	sorted_double_ended_list i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	list_cmd_t                 op_queue[$];
	out_item_t                 list_replies_due[$];
	logic signed [KEY_W-1:0]   recent_keys[$];
	logic signed [KEY_W-1:0]   shadow_keys[$];
	logic [TAG_W-1:0]          shadow_tags[$];
	int                        mismatch_count = 0;
	logic                      in_taken;
	int                        burst_left = 0;
	int                        gap_left = 0;
	logic [5:0]                ready_phase = '0;
	logic [15:0]               ready_pattern = 16'hFFFF;
	list_cmd_t                 next_cmd;
	out_item_t                 got_reply;
	out_item_t                 want_reply;

	// clock, reset and known input levels from time zero
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.data    = '0;
		out_ch.ready  = 1'b0;
		fork
			forever #5 clk = ~clk;
			begin
				repeat (6) @(posedge clk);
				@(negedge clk);
				arst_n = 1'b1;
			end
		join_none
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// compute the reply for one operation and update the shadow list
	function automatic out_item_t apply_list_op(in_item_t op);
		out_item_t res;
		int        pos;
		int        hit;
		res        = '0;
		res.status = ST_OK;
		hit        = -1;
		case (op.mode)
			MODE_PUSH_HEAD, MODE_PUSH_TAIL, MODE_SORTED: begin
				if (shadow_keys.size() >= SDEL_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					pos = shadow_keys.size();
					if (op.mode == MODE_PUSH_HEAD) begin
						pos = 0;
					end else if (op.mode == MODE_SORTED) begin
						// smaller than head goes first, not below tail goes last,
						// else in front of the first larger key
						if (shadow_keys.size() == 0 || op.key < shadow_keys[0]) begin
							pos = 0;
						end else if (!(op.key >= shadow_keys[$])) begin
							for (int i = 0; i < shadow_keys.size(); i++) begin
								if (shadow_keys[i] > op.key) begin
									pos = i;
									break;
								end
							end
						end
					end
					shadow_keys.insert(pos, op.key);
					shadow_tags.insert(pos, op.payload);
				end
			end
			MODE_POP_HEAD, MODE_POP_TAIL, MODE_REMOVE: begin
				if (shadow_keys.size() == 0) begin
					res.status = ST_EMPTY;
				end else begin
					if (op.mode == MODE_POP_HEAD) begin
						hit = 0;
					end else if (op.mode == MODE_POP_TAIL) begin
						hit = shadow_keys.size() - 1;
					end else if (shadow_keys[0] == op.key) begin
						hit = 0;
					end else if (shadow_keys[$] == op.key) begin
						hit = shadow_keys.size() - 1;
					end else begin
						for (int i = 0; i < shadow_keys.size(); i++) begin
							if (shadow_keys[i] == op.key) begin
								hit = i;
								break;
							end
						end
					end
					if (hit < 0) begin
						res.status = ST_NOTFOUND;
					end else begin
						res.out_key     = shadow_keys[hit];
						res.out_payload = shadow_tags[hit];
						shadow_keys.delete(hit);
						shadow_tags.delete(hit);
					end
				end
			end
			default: begin
			end
		endcase
		res.out_count = OUT_COUNT_W'(shadow_keys.size());
		return res;
	endfunction

	// append an operation; remember pushed keys so removals can find them
	task automatic queue_op(logic [2:0] mode, logic signed [KEY_W-1:0] key,
			logic [TAG_W-1:0] payload, bit drain);
		list_cmd_t cmd;
		cmd.item.mode    = mode;
		cmd.item.key     = key;
		cmd.item.payload = payload;
		cmd.drain        = drain;
		op_queue.push_back(cmd);
		if (mode == MODE_PUSH_HEAD || mode == MODE_PUSH_TAIL || mode == MODE_SORTED) begin
			recent_keys.push_back(key);
			if (recent_keys.size() > 16)
				void'(recent_keys.pop_front());
		end
	endtask

	// mix of recent keys, a narrow band, extremes and full-range values
	function automatic logic signed [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35 && recent_keys.size() != 0)
			return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		if (r < 55)
			return int'($urandom_range(0, 16)) - 8;
		if (r < 65) begin
			case ($urandom_range(0, 3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return -1;
				default: return 0;
			endcase
		end
		return $urandom;
	endfunction

	// stimulus: directed corner cases, then random segments, then wind down
	initial begin
		int         seg_kind;
		int         seg_len;
		int         n_random;
		int         r;
		logic [2:0] mode;
		logic signed [KEY_W-1:0] key;

		// empty store on every removal mode, reserved modes on empty store
		queue_op(MODE_POP_HEAD, 0, 0, 1'b0);
		queue_op(MODE_POP_TAIL, 0, 0, 1'b0);
		queue_op(MODE_REMOVE, 5, 0, 1'b0);
		queue_op(MODE_RSVD_6, KEY_MAX, 32'hFFFF_FFFF, 1'b0);
		queue_op(MODE_RSVD_7, KEY_MIN, 32'h1234_5678, 1'b0);
		// sorted insert: first entry, new head, new tail, middle, duplicate
		queue_op(MODE_SORTED, 0, 32'h0000_00A1, 1'b0);
		queue_op(MODE_SORTED, KEY_MIN, 32'h0000_00A2, 1'b0);
		queue_op(MODE_SORTED, KEY_MAX, 32'h0000_00A3, 1'b0);
		queue_op(MODE_SORTED, 5, 32'h0000_00A4, 1'b0);
		queue_op(MODE_SORTED, 5, 32'h0000_00A5, 1'b0);
		// unsorted ends
		queue_op(MODE_PUSH_HEAD, 100, 32'hFFFF_FFFF, 1'b0);
		queue_op(MODE_PUSH_TAIL, -7, 32'h0000_0000, 1'b0);
		// remove by key: head match, tail match, middle first match, miss
		queue_op(MODE_REMOVE, 100, 0, 1'b0);
		queue_op(MODE_REMOVE, -7, 0, 1'b0);
		queue_op(MODE_REMOVE, 5, 0, 1'b0);
		queue_op(MODE_REMOVE, 12345, 0, 1'b0);
		queue_op(MODE_POP_HEAD, 0, 0, 1'b0);
		queue_op(MODE_POP_TAIL, 0, 0, 1'b0);
		// tail match wins over an earlier duplicate in the middle
		queue_op(MODE_PUSH_TAIL, 5, 32'h5A5A_A5A5, 1'b0);
		queue_op(MODE_PUSH_TAIL, 9, 32'h0000_00B1, 1'b0);
		queue_op(MODE_PUSH_TAIL, 5, 32'hC3C3_3C3C, 1'b0);
		queue_op(MODE_REMOVE, 5, 0, 1'b0);
		queue_op(MODE_REMOVE, 5, 0, 1'b0);

		// random: fill past full, drain past empty, then mixed segments
		n_random = 0;
		seg_kind = 0;
		while (n_random < RANDOM_OPS) begin
			seg_len = (n_random < 50) ? 22 : $urandom_range(8, 30);
			for (int i = 0; i < seg_len; i++) begin
				r = $urandom_range(0, 99);
				case (seg_kind)
					0: mode = 3'($urandom_range(MODE_PUSH_HEAD, MODE_SORTED));
					1: mode = 3'($urandom_range(MODE_POP_HEAD, MODE_REMOVE));
					2: mode = 3'((r < 70) ? $urandom_range(MODE_PUSH_HEAD, MODE_SORTED)
						: $urandom_range(MODE_POP_HEAD, MODE_REMOVE));
					3: mode = 3'((r < 70) ? $urandom_range(MODE_POP_HEAD, MODE_REMOVE)
						: $urandom_range(MODE_PUSH_HEAD, MODE_SORTED));
					default: mode = 3'($urandom_range(MODE_PUSH_HEAD, MODE_RSVD_7));
				endcase
				if (mode == MODE_REMOVE && recent_keys.size() != 0 && $urandom_range(0, 3) != 0)
					key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
				else
					key = pick_key();
				queue_op(mode, key, $urandom, (n_random == 0) || ($urandom_range(0, 99) == 0));
				n_random++;
			end
			seg_kind = (n_random < 50) ? 1 : $urandom_range(0, 4);
		end

		// wait for the last transaction, every reply, then a short tail
		wait (op_queue.size() == 0);
		@(negedge clk);
		wait (!in_ch.valid);
		wait (list_replies_due.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// sender: bursts of transactions separated by random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && !in_taken) begin
				// hold the offered transaction until it is taken
			end else if (gap_left != 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (op_queue.size() != 0 &&
					!(op_queue[0].drain && list_replies_due.size() != 0)) begin
				next_cmd = op_queue.pop_front();
				in_ch.data  <= next_cmd.item;
				in_ch.valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left--;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: stall on a pattern that is redrawn each time the phase counter wraps
	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_phase == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pattern = 16'hFFFF;
					1: ready_pattern = 16'($urandom) | 16'h8000;
					2: ready_pattern = 16'h00FF;
					default: ready_pattern = 16'hAAAA;
				endcase
			end
			out_ch.ready <= ready_pattern[ready_phase[3:0]];
			ready_phase = ready_phase + 1'b1;
		end
	end

	// monitor: check replies first, then predict for the accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (out_ch.valid && out_ch.ready) begin
				got_reply = out_ch.data;
				if (list_replies_due.size() == 0) begin
					report_mismatch("reply with none pending, status",
						32'(got_reply.status), 0);
				end else begin
					want_reply = list_replies_due.pop_front();
					if (got_reply.status !== want_reply.status)
						report_mismatch("status", 32'(got_reply.status),
							32'(want_reply.status));
					if (got_reply.out_key !== want_reply.out_key)
						report_mismatch("out_key", got_reply.out_key, want_reply.out_key);
					if (got_reply.out_payload !== want_reply.out_payload)
						report_mismatch("out_payload", got_reply.out_payload,
							want_reply.out_payload);
					if (got_reply.out_count !== want_reply.out_count)
						report_mismatch("out_count", 32'(got_reply.out_count),
							32'(want_reply.out_count));
				end
			end
			if (in_ch.valid && in_ch.ready)
				list_replies_due.push_back(apply_list_op(in_ch.data));
		end
	end

endmodule
